FILE: rtl/core/mpc_pkg.sv
// Package for the midpoint circle point generator: widths, codes and the
// payload structs shared by the front, queue, back and checker modules.
// No dependencies.
`default_nettype none

package mpc_pkg;

  localparam int unsigned COORD_WIDTH  = 16;
  localparam int unsigned RADIUS_WIDTH = 12;

  // step_x never passes radius/sqrt(2)+1; step_y spans -1..radius
  localparam int unsigned STEPX_W = RADIUS_WIDTH + 1;
  localparam int unsigned STEPY_W = RADIUS_WIDTH + 2;
  localparam int unsigned DEC_W   = RADIUS_WIDTH + 12;
  localparam int unsigned SUM_W   = COORD_WIDTH + STEPY_W;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned Q_IDX_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  localparam logic signed [DEC_W-1:0] DEC_INIT = DEC_W'(3);
  localparam logic signed [DEC_W-1:0] DEC_DIAG = DEC_W'(10);
  localparam logic signed [DEC_W-1:0] DEC_AXIS = DEC_W'(6);

  typedef enum logic [0:0] {
    CMD_START   = 1'b0,
    CMD_ADVANCE = 1'b1
  } cmd_e;

  // Eight symmetric slots of one group, in emission order (offsets x, z).
  typedef enum logic [2:0] {
    SLOT_PX_PY = 3'd0,
    SLOT_NX_PY = 3'd1,
    SLOT_PX_NY = 3'd2,
    SLOT_NX_NY = 3'd3,
    SLOT_PY_PX = 3'd4,
    SLOT_NY_PX = 3'd5,
    SLOT_PY_NX = 3'd6,
    SLOT_NY_NX = 3'd7
  } slot_e;

  typedef struct packed {
    cmd_e                           command;
    logic signed [COORD_WIDTH-1:0]  center_x;
    logic signed [COORD_WIDTH-1:0]  center_z;
    logic        [RADIUS_WIDTH-1:0] radius;
    logic signed [COORD_WIDTH-1:0]  plane_y;
  } item_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] point_z;
    logic                          group_last;
    logic                          circle_done;
  } result_t;

  // One group of eight points, as handed from front to back.
  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] center_x;
    logic signed [COORD_WIDTH-1:0] center_z;
    logic signed [COORD_WIDTH-1:0] plane_y;
    logic        [STEPX_W-1:0]     step_x;
    logic signed [STEPY_W-1:0]     step_y;
    logic                          done;
  } group_t;

endpackage

`default_nettype wire

FILE: rtl/core/mpc_front.sv
// Front end: accepts commands, keeps the circle state and pushes a group
// descriptor per start and per midpoint step run by an advance. Depends on mpc_pkg.
`default_nettype none

module mpc_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           accept_i,
  input  wire mpc_pkg::item_t item_i,
  output logic                grp_push_o,
  output mpc_pkg::group_t     grp_o
);

  logic signed [mpc_pkg::COORD_WIDTH-1:0] cx_q, cx_d;
  logic signed [mpc_pkg::COORD_WIDTH-1:0] cz_q, cz_d;
  logic signed [mpc_pkg::COORD_WIDTH-1:0] py_q, py_d;
  logic        [mpc_pkg::STEPX_W-1:0]     step_x_q, step_x_d;
  logic signed [mpc_pkg::STEPY_W-1:0]     step_y_q, step_y_d;
  logic signed [mpc_pkg::DEC_W-1:0]       dec_q, dec_d;
  logic                                   running_q, running_d;

  logic                                   is_start;
  logic                                   dec_pos;
  logic        [mpc_pkg::STEPX_W-1:0]     x_inc;
  logic signed [mpc_pkg::STEPY_W-1:0]     y_nxt;
  logic signed [mpc_pkg::STEPY_W:0]       xs, ys, diff;
  logic signed [mpc_pkg::DEC_W-1:0]       dec_step;
  logic signed [mpc_pkg::DEC_W-1:0]       dec_init;
  logic signed [mpc_pkg::STEPY_W-1:0]     y_init;
  logic                                   done;

  assign is_start = (item_i.command == mpc_pkg::CMD_START);

  always_comb begin
    dec_pos = !dec_q[mpc_pkg::DEC_W-1] && (dec_q != '0);
    x_inc   = step_x_q + 1'b1;
    y_nxt   = dec_pos ? (step_y_q - 1'b1) : step_y_q;
    xs      = $signed({2'b00, x_inc});
    ys      = {y_nxt[mpc_pkg::STEPY_W-1], y_nxt};
    diff    = xs - ys;
    if (dec_pos) begin
      dec_step = dec_q + mpc_pkg::DEC_DIAG
               + $signed({{(mpc_pkg::DEC_W-mpc_pkg::STEPY_W-3){diff[mpc_pkg::STEPY_W]}},
                          diff, 2'b00});
    end else begin
      dec_step = dec_q + mpc_pkg::DEC_AXIS
               + $signed({{(mpc_pkg::DEC_W-mpc_pkg::STEPY_W-3){1'b0}}, xs, 2'b00});
    end
    done     = (ys < xs);
    dec_init = mpc_pkg::DEC_INIT
             - $signed({{(mpc_pkg::DEC_W-mpc_pkg::RADIUS_WIDTH-1){1'b0}}, item_i.radius, 1'b0});
    y_init   = $signed({2'b00, item_i.radius});
  end

  always_comb begin
    cx_d       = cx_q;
    cz_d       = cz_q;
    py_d       = py_q;
    step_x_d   = step_x_q;
    step_y_d   = step_y_q;
    dec_d      = dec_q;
    running_d  = running_q;
    grp_push_o = 1'b0;
    grp_o.center_x = cx_q;
    grp_o.center_z = cz_q;
    grp_o.plane_y  = py_q;
    grp_o.step_x   = x_inc;
    grp_o.step_y   = y_nxt;
    grp_o.done     = done;
    if (accept_i && is_start) begin
      cx_d       = item_i.center_x;
      cz_d       = item_i.center_z;
      py_d       = item_i.plane_y;
      step_x_d   = '0;
      step_y_d   = y_init;
      dec_d      = dec_init;
      running_d  = 1'b1;
      grp_push_o = 1'b1;
      grp_o.center_x = item_i.center_x;
      grp_o.center_z = item_i.center_z;
      grp_o.plane_y  = item_i.plane_y;
      grp_o.step_x   = '0;
      grp_o.step_y   = y_init;
      grp_o.done     = 1'b0;
    end else if (accept_i && running_q) begin
      step_x_d   = x_inc;
      step_y_d   = y_nxt;
      dec_d      = dec_step;
      running_d  = !done;
      grp_push_o = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q      <= '0;
      cz_q      <= '0;
      py_q      <= '0;
      step_x_q  <= '0;
      step_y_q  <= '0;
      dec_q     <= '0;
      running_q <= 1'b0;
    end else begin
      cx_q      <= cx_d;
      cz_q      <= cz_d;
      py_q      <= py_d;
      step_x_q  <= step_x_d;
      step_y_q  <= step_y_d;
      dec_q     <= dec_d;
      running_q <= running_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/mpc_queue.sv
// Short group queue between front and back, register based.
// Depends on mpc_pkg.
`default_nettype none

module mpc_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire mpc_pkg::group_t data_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output mpc_pkg::group_t      data_o,
  output logic                 empty_o
);

  mpc_pkg::group_t              mem_q [mpc_pkg::QUEUE_DEPTH];
  logic [mpc_pkg::Q_IDX_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [mpc_pkg::Q_IDX_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [mpc_pkg::Q_IDX_W:0]    cnt_q, cnt_d;
  logic                         do_push, do_pop;

  assign full_o  = (cnt_q == (mpc_pkg::Q_IDX_W+1)'(mpc_pkg::QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  function automatic logic [mpc_pkg::Q_IDX_W-1:0] ptr_inc(
    input logic [mpc_pkg::Q_IDX_W-1:0] p
  );
    if (p == mpc_pkg::Q_IDX_W'(mpc_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_d = do_push ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/mpc_back.sv
// Back end: walks a group's eight symmetric slots into the result register,
// one point per cycle while no point waits unpopped. Depends on mpc_pkg.
`default_nettype none

module mpc_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire mpc_pkg::group_t grp_i,
  input  wire logic            grp_empty_i,
  output logic                 grp_pop_o,
  output mpc_pkg::result_t     result_o,
  output logic                 empty_o,
  input  wire logic            pop_i
);

  mpc_pkg::group_t   grp_q, grp_d;
  mpc_pkg::slot_e    slot_q, slot_d;
  logic              active_q, active_d;
  mpc_pkg::result_t  res_q, res_d;
  logic              vld_q, vld_d;

  logic                                 out_rdy, emit, last, load;
  logic signed [mpc_pkg::STEPY_W-1:0]   ofs_a, ofs_b, ofs_x, ofs_z;
  logic signed [mpc_pkg::SUM_W-1:0]     sum_x, sum_z;
  mpc_pkg::result_t                     pt;

  assign out_rdy = !vld_q || pop_i;
  assign emit    = active_q && out_rdy;
  assign last    = (slot_q == mpc_pkg::SLOT_NY_NX);
  assign load    = !grp_empty_i && (!active_q || (emit && last));
  assign grp_pop_o = load;

  always_comb begin
    ofs_a = $signed({1'b0, grp_q.step_x});
    ofs_b = grp_q.step_y;
    unique case (slot_q)
      mpc_pkg::SLOT_PX_PY: begin ofs_x =  ofs_a; ofs_z =  ofs_b; end
      mpc_pkg::SLOT_NX_PY: begin ofs_x = -ofs_a; ofs_z =  ofs_b; end
      mpc_pkg::SLOT_PX_NY: begin ofs_x =  ofs_a; ofs_z = -ofs_b; end
      mpc_pkg::SLOT_NX_NY: begin ofs_x = -ofs_a; ofs_z = -ofs_b; end
      mpc_pkg::SLOT_PY_PX: begin ofs_x =  ofs_b; ofs_z =  ofs_a; end
      mpc_pkg::SLOT_NY_PX: begin ofs_x = -ofs_b; ofs_z =  ofs_a; end
      mpc_pkg::SLOT_PY_NX: begin ofs_x =  ofs_b; ofs_z = -ofs_a; end
      mpc_pkg::SLOT_NY_NX: begin ofs_x = -ofs_b; ofs_z = -ofs_a; end
      default:             begin ofs_x =  ofs_a; ofs_z =  ofs_b; end
    endcase
    // wrap modulo 2^COORD_WIDTH: add wide, keep the low bits
    sum_x = {{mpc_pkg::STEPY_W{grp_q.center_x[mpc_pkg::COORD_WIDTH-1]}}, grp_q.center_x}
          + {{mpc_pkg::COORD_WIDTH{ofs_x[mpc_pkg::STEPY_W-1]}}, ofs_x};
    sum_z = {{mpc_pkg::STEPY_W{grp_q.center_z[mpc_pkg::COORD_WIDTH-1]}}, grp_q.center_z}
          + {{mpc_pkg::COORD_WIDTH{ofs_z[mpc_pkg::STEPY_W-1]}}, ofs_z};
    pt.point_x     = sum_x[mpc_pkg::COORD_WIDTH-1:0];
    pt.point_y     = grp_q.plane_y;
    pt.point_z     = sum_z[mpc_pkg::COORD_WIDTH-1:0];
    pt.group_last  = last;
    pt.circle_done = grp_q.done;
  end

  always_comb begin
    grp_d    = load ? grp_i : grp_q;
    slot_d   = slot_q;
    active_d = active_q;
    if (load) begin
      slot_d   = mpc_pkg::SLOT_PX_PY;
      active_d = 1'b1;
    end else if (emit) begin
      slot_d   = mpc_pkg::slot_e'(slot_q + 3'd1);
      active_d = !last;
    end
    res_d = emit ? pt : res_q;
    vld_d = emit ? 1'b1 : (pop_i ? 1'b0 : vld_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q   <= mpc_pkg::SLOT_PX_PY;
      active_q <= 1'b0;
      vld_q    <= 1'b0;
    end else begin
      slot_q   <= slot_d;
      active_q <= active_d;
      vld_q    <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    grp_q <= grp_d;
    res_q <= res_d;
  end

  assign result_o = res_q;
  assign empty_o  = !vld_q;

endmodule

`default_nettype wire

FILE: rtl/core/midpoint_circle_points_top.sv
// Top level of the midpoint circle point generator: front, group queue and
// back. Depends on mpc_pkg, mpc_front, mpc_queue and mpc_back.
//
//   channel   handshake              payload             transfer when
//   -------   --------------------   -----------------   ------------------
//   command   push (in) / full (out) item_i   (item_t)   push && !full
//   points    empty (out) / pop (in) result_o (result_t) pop && !empty
//
// A start or advance command is taken whenever the group queue has room;
// on an advance with a circle running, the front runs one midpoint step in
// that cycle. Each group yields eight points through the one-point result
// register, walked by the back's slot counter. A group's first point passes
// through the queue, the back's group register and the result register.
// An advance with no circle running is accepted and yields nothing.
// Reset (asynchronous, active low) empties queue and result register and
// drops any running circle. A stalled pop holds the point; the queue keeps
// taking commands until it fills.
`default_nettype none

module midpoint_circle_points_top (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push,
  output logic                full,
  input  wire mpc_pkg::item_t item_i,
  output logic                empty,
  input  wire logic           pop,
  output mpc_pkg::result_t    result_o
);

  logic             accept;
  logic             grp_push;
  mpc_pkg::group_t  grp_in;
  mpc_pkg::group_t  grp_out;
  logic             grp_empty;
  logic             grp_pop;

  // a command transfers whenever the queue has a free slot
  assign accept = push && !full;

  mpc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .item_i     (item_i),
    .grp_push_o (grp_push),
    .grp_o      (grp_in)
  );

  mpc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (grp_push),
    .data_i  (grp_in),
    .full_o  (full),
    .pop_i   (grp_pop),
    .data_o  (grp_out),
    .empty_o (grp_empty)
  );

  mpc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .grp_i       (grp_out),
    .grp_empty_i (grp_empty),
    .grp_pop_o   (grp_pop),
    .result_o    (result_o),
    .empty_o     (empty),
    .pop_i       (pop)
  );

endmodule

`default_nettype wire

FILE: rtl/core/mpc_checker.sv
// Port-level checker for midpoint_circle_points_top, attached by bind.
// Depends on mpc_pkg.
`default_nettype none

module mpc_checker (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             empty,
  input wire logic             pop,
  input wire mpc_pkg::result_t result_o
);

  // a waiting point is held until popped
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(result_o))
    else $error("result changed while waiting");

  // points of a group come without gaps
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !empty && !result_o.group_last |=> !empty)
    else $error("gap inside a point group");

  // plane height and final flag are shared by all points of a group
  a_group_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !empty && !result_o.group_last |=>
      (result_o.point_y == $past(result_o.point_y)) &&
      (result_o.circle_done == $past(result_o.circle_done)))
    else $error("group fields differ inside a group");

  // the first point of a group sits at center offset (+x,+y): after a group
  // ends, the next group's second point mirrors the first about the center x
  a_mirror: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !empty && result_o.group_last |=>
      ##0 (!empty && pop) |=> (empty ||
        (result_o.point_z == $past(result_o.point_z))))
    else $error("slot order broken at group start");

endmodule

bind midpoint_circle_points_top mpc_checker u_mpc_checker (.*);

`default_nettype wire
